[hw/rtl/mksc_pkg.sv]
// Package with the shared types, codes and reset values of the Morse key symbol classifier.
`timescale 1ns / 1ps
`default_nettype none

package mksc_pkg;

    localparam int TIME_BITS_DEF = 16;

    localparam int CFG_W      = 16;
    localparam int LINE_W     = 6;
    localparam int ACTION_W   = 2;
    localparam int SYMBOL_W   = 3;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_PRESS   = 2'd1,
        ACT_RELEASE = 2'd2
    } act_t;

    typedef enum logic [SYMBOL_W-1:0] {
        SYM_NONE    = 3'd0,
        SYM_DOT     = 3'd1,
        SYM_DASH    = 3'd2,
        SYM_UNKNOWN = 3'd3,
        SYM_HOLD    = 3'd4,
        SYM_SHORT   = 3'd5,
        SYM_LONG    = 3'd6
    } sym_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOT_TIME        = 3'd0,
        REG_DASH_TIME       = 3'd1,
        REG_TOLERANCE       = 3'd2,
        REG_HOLD_TIME       = 3'd3,
        REG_LONG_SPACE_TIME = 3'd4,
        REG_LEFT_PADDLE     = 3'd5,
        REG_RIGHT_PADDLE    = 3'd6
    } cfg_idx_t;

    localparam logic [CFG_W-1:0]  DOT_TIME_RST        = 16'd100;
    localparam logic [CFG_W-1:0]  DASH_TIME_RST       = 16'd300;
    localparam logic [CFG_W-1:0]  TOLERANCE_RST       = 16'd50;
    localparam logic [CFG_W-1:0]  HOLD_TIME_RST       = 16'd2000;
    localparam logic [CFG_W-1:0]  LONG_SPACE_TIME_RST = 16'd700;
    localparam logic [LINE_W-1:0] LEFT_PADDLE_RST     = 6'd0;
    localparam logic [LINE_W-1:0] RIGHT_PADDLE_RST    = 6'd1;

    typedef struct packed {
        logic [CFG_W-1:0]  dot_time;
        logic [CFG_W-1:0]  dash_time;
        logic [CFG_W-1:0]  tolerance;
        logic [CFG_W-1:0]  hold_time;
        logic [CFG_W-1:0]  long_space_time;
        logic [LINE_W-1:0] left_paddle_line;
        logic [LINE_W-1:0] right_paddle_line;
    } cfg_t;

endpackage

`default_nettype wire

[hw/rtl/mksc_if.sv]
// Handshake interfaces for the key event, symbol and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface mksc_in_if;
    import mksc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [LINE_W-1:0]   line;

    modport source (output valid, output action, output line, input ready);
    modport sink   (input valid, input action, input line, output ready);
endinterface

interface mksc_out_if;
    import mksc_pkg::*;

    logic                valid;
    logic                ready;
    logic [SYMBOL_W-1:0] symbol;
    logic                tone_on;

    modport source (output valid, output symbol, output tone_on, input ready);
    modport sink   (input valid, input symbol, input tone_on, output ready);
endinterface

interface mksc_cfg_if;
    import mksc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/mksc_cfg.sv]
// Configuration register file of the Morse key symbol classifier.
`timescale 1ns / 1ps
`default_nettype none

module mksc_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    mksc_cfg_if.sink          cfg_ch,
    output mksc_pkg::cfg_t    cfg
);
    import mksc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg          = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_DOT_TIME:        cfg_next.dot_time          = cfg_ch.data;
                REG_DASH_TIME:       cfg_next.dash_time         = cfg_ch.data;
                REG_TOLERANCE:       cfg_next.tolerance         = cfg_ch.data;
                REG_HOLD_TIME:       cfg_next.hold_time         = cfg_ch.data;
                REG_LONG_SPACE_TIME: cfg_next.long_space_time   = cfg_ch.data;
                REG_LEFT_PADDLE:     cfg_next.left_paddle_line  = cfg_ch.data[LINE_W-1:0];
                REG_RIGHT_PADDLE:    cfg_next.right_paddle_line = cfg_ch.data[LINE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dot_time          <= DOT_TIME_RST;
            cfg_reg.dash_time         <= DASH_TIME_RST;
            cfg_reg.tolerance         <= TOLERANCE_RST;
            cfg_reg.hold_time         <= HOLD_TIME_RST;
            cfg_reg.long_space_time   <= LONG_SPACE_TIME_RST;
            cfg_reg.left_paddle_line  <= LEFT_PADDLE_RST;
            cfg_reg.right_paddle_line <= RIGHT_PADDLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/mksc_core.sv]
// Key timing state, symbol classification and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module mksc_core #(
    parameter int TIME_BITS = mksc_pkg::TIME_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire mksc_pkg::cfg_t cfg,
    mksc_in_if.sink            in_ch,
    mksc_out_if.source         out_ch
);
    import mksc_pkg::*;

    // Comparison width: covers the counters, the 16 bit registers and one carry.
    localparam int CW = ((TIME_BITS > CFG_W) ? TIME_BITS : CFG_W) + 1;
    localparam logic [CW-1:0] TIME_MAX = {{(CW-TIME_BITS){1'b0}}, {TIME_BITS{1'b1}}};

    function automatic logic [CW-1:0] ext_cfg(input logic [CFG_W-1:0] v);
        ext_cfg = {{(CW-CFG_W){1'b0}}, v};
    endfunction

    function automatic logic [CW-1:0] ext_time(input logic [TIME_BITS-1:0] v);
        ext_time = {{(CW-TIME_BITS){1'b0}}, v};
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_load(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ve;
        ve = ext_cfg(v);
        sat_load = (ve > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : ve[TIME_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
        sat_inc = (v == {TIME_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] floor_sub(input logic [CFG_W-1:0] a,
                                                   input logic [CFG_W-1:0] b);
        floor_sub = (a > b) ? a - b : '0;
    endfunction

    logic                 key_down_reg,       key_down_next;
    logic [TIME_BITS-1:0] press_elapsed_reg,  press_elapsed_next;
    logic [TIME_BITS-1:0] idle_elapsed_reg,   idle_elapsed_next;
    logic                 idle_armed_reg,     idle_armed_next;
    logic                 short_sent_reg,     short_sent_next;
    logic [TIME_BITS-1:0] tone_remaining_reg, tone_remaining_next;

    logic                 out_valid_reg;
    logic [SYMBOL_W-1:0]  symbol_reg;
    logic                 tone_on_reg;

    sym_t                 sym_next;
    logic                 in_accept;
    logic [TIME_BITS-1:0] press_inc;
    logic [TIME_BITS-1:0] idle_inc;
    logic [CW-1:0]        press_ext;
    logic                 in_dot_window;
    logic                 in_dash_window;
    logic                 is_left;
    logic                 is_right;

    assign in_ch.ready    = !out_valid_reg || out_ch.ready;
    assign in_accept      = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.symbol  = symbol_reg;
    assign out_ch.tone_on = tone_on_reg;

    assign press_inc = sat_inc(press_elapsed_reg);
    assign idle_inc  = sat_inc(idle_elapsed_reg);
    assign press_ext = ext_time(press_elapsed_reg);
    assign is_left   = (in_ch.line == cfg.left_paddle_line);
    assign is_right  = (in_ch.line == cfg.right_paddle_line);

    assign in_dot_window =
        (press_ext >= ext_cfg(floor_sub(cfg.dot_time, cfg.tolerance))) &&
        (press_ext <= ext_cfg(cfg.dot_time) + ext_cfg(cfg.tolerance));
    assign in_dash_window =
        (press_ext >= ext_cfg(floor_sub(cfg.dash_time, cfg.tolerance))) &&
        (press_ext <= ext_cfg(cfg.dash_time) + ext_cfg(cfg.tolerance));

    always_comb
    begin
        key_down_next       = key_down_reg;
        press_elapsed_next  = press_elapsed_reg;
        idle_elapsed_next   = idle_elapsed_reg;
        idle_armed_next     = idle_armed_reg;
        short_sent_next     = short_sent_reg;
        tone_remaining_next = tone_remaining_reg;
        sym_next            = SYM_NONE;

        case (in_ch.action)
            ACT_TICK:
            begin
                if (tone_remaining_reg != '0)
                begin
                    tone_remaining_next = tone_remaining_reg - 1'b1;
                    idle_elapsed_next   = '0;
                end
                else if (key_down_reg)
                begin
                    press_elapsed_next = press_inc;
                    if (ext_time(press_inc) >= ext_cfg(cfg.hold_time))
                    begin
                        sym_next          = SYM_HOLD;
                        key_down_next     = 1'b0;
                        idle_elapsed_next = '0;
                        idle_armed_next   = 1'b1;
                    end
                end
                else
                begin
                    idle_elapsed_next = idle_inc;
                    if (idle_armed_reg &&
                        ext_time(idle_inc) > ext_cfg(cfg.long_space_time))
                    begin
                        sym_next        = SYM_LONG;
                        idle_armed_next = 1'b0;
                    end
                    else if (idle_armed_reg && !short_sent_reg &&
                             ext_time(idle_inc) >=
                             ext_cfg(floor_sub(cfg.dash_time, cfg.tolerance)))
                    begin
                        sym_next        = SYM_SHORT;
                        short_sent_next = 1'b1;
                    end
                end
            end
            ACT_PRESS:
            begin
                if (is_left || is_right)
                begin
                    if (is_left)
                    begin
                        sym_next            = SYM_DOT;
                        tone_remaining_next = sat_load(cfg.dot_time);
                    end
                    else
                    begin
                        sym_next            = SYM_DASH;
                        tone_remaining_next = sat_load(cfg.dash_time);
                    end
                    key_down_next     = 1'b0;
                    idle_elapsed_next = '0;
                    idle_armed_next   = 1'b1;
                    short_sent_next   = 1'b0;
                end
                else
                begin
                    tone_remaining_next = '0;
                    press_elapsed_next  = '0;
                    key_down_next       = 1'b1;
                    short_sent_next     = 1'b0;
                end
            end
            ACT_RELEASE:
            begin
                idle_elapsed_next = '0;
                idle_armed_next   = 1'b1;
                if (key_down_reg)
                begin
                    key_down_next = 1'b0;
                    if (in_dot_window)
                    begin
                        sym_next = SYM_DOT;
                    end
                    else if (in_dash_window)
                    begin
                        sym_next = SYM_DASH;
                    end
                    else
                    begin
                        sym_next = SYM_UNKNOWN;
                    end
                end
            end
            default:
            begin
                sym_next = SYM_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_down_reg       <= 1'b0;
            press_elapsed_reg  <= '0;
            idle_elapsed_reg   <= '0;
            idle_armed_reg     <= 1'b1;
            short_sent_reg     <= 1'b0;
            tone_remaining_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                key_down_reg       <= key_down_next;
                press_elapsed_reg  <= press_elapsed_next;
                idle_elapsed_reg   <= idle_elapsed_next;
                idle_armed_reg     <= idle_armed_next;
                short_sent_reg     <= short_sent_next;
                tone_remaining_reg <= tone_remaining_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            symbol_reg  <= sym_next;
            tone_on_reg <= key_down_next || (tone_remaining_next != '0);
        end
    end

    // A straight key press and a paddle tone never run together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(key_down_reg && (tone_remaining_reg != '0)))
        else $error("straight key down while a paddle tone runs");

    // The tone flag of a result matches the state that the same item left.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (tone_on_reg == (key_down_reg || (tone_remaining_reg != '0))))
        else $error("tone flag disagrees with the timing state");

    // The block takes a new item whenever the result register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ch.ready)
        else $error("input stalled with an empty result register");

    // A tick during a paddle tone keeps the idle timer at zero and gives no symbol.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_ch.action == ACT_TICK) && (tone_remaining_reg != '0))
        |=> ((idle_elapsed_reg == '0) && (symbol_reg == SYM_NONE)))
        else $error("tick during a paddle tone moved the idle timer");

endmodule

`default_nettype wire

[hw/rtl/morse_key_symbol_classifier_top.sv]
// Top level of the Morse key symbol classifier.
//
//  Channel   Role    Payload                       Transfer
//  events    sink    action[1:0], line[5:0]        valid && ready
//  symbols   source  symbol[2:0], tone_on          valid && ready
//  cfg       sink    index[2:0], data[15:0]        valid && ready (ready tied high)
//
// The timing state and the classification are computed in the cycle of acceptance and
// the result appears in the result register in the cycle after.
// A new item is accepted every cycle while the result register is empty or being taken.
// When the symbols channel stalls, the held result blocks the events channel only.
// Reset loads the register defaults and a released, idle key with the idle timer armed.
`timescale 1ns / 1ps
`default_nettype none

module morse_key_symbol_classifier_top #(
    parameter int TIME_BITS = mksc_pkg::TIME_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mksc_in_if.sink     events,
    mksc_out_if.source  symbols,
    mksc_cfg_if.sink    cfg
);
    import mksc_pkg::*;

    cfg_t cfg_regs;

    mksc_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg),
        .cfg    (cfg_regs)
    );

    mksc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_regs),
        .in_ch  (events),
        .out_ch (symbols)
    );

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench that drives key events into the Morse key symbol classifier and checks each symbol item.
`timescale 1ns / 1ps

module testbench;
    import mksc_pkg::*;

    localparam int TIME_BITS    = TIME_BITS_DEF;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 2;

    typedef struct packed {
        sym_t symbol;
        logic tone_on;
    } key_symbol_t;

    typedef struct {
        logic                 key_down;
        logic [TIME_BITS-1:0] press_ms;
        logic [TIME_BITS-1:0] idle_ms;
        logic                 idle_armed;
        logic                 short_sent;
        logic [TIME_BITS-1:0] tone_left;
    } keyer_state_t;

    logic clk;
    logic rst_n;

    mksc_in_if  events_if ();
    mksc_out_if symbols_if ();
    mksc_cfg_if cfg_if ();

    morse_key_symbol_classifier_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .events  (events_if),
        .symbols (symbols_if),
        .cfg     (cfg_if)
    );

    cfg_t          key_cfg;
    keyer_state_t  key_st;
    key_symbol_t   pending_symbols[$];
    int            error_count    = 0;
    int            events_sent    = 0;
    int            src_gap_pct    = 7;
    int            sink_stall_pct = 7;
    int            sink_holdoff   = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [TIME_BITS-1:0] tone_length(input logic [CFG_W-1:0] value);
        return ((value >> TIME_BITS) != 0) ? '1 : TIME_BITS'(value);
    endfunction

    function automatic bit within_window(input logic [TIME_BITS-1:0] len,
                                         input logic [CFG_W-1:0] nominal);
        longint lo;
        longint hi;
        lo = (nominal > key_cfg.tolerance) ? longint'(nominal - key_cfg.tolerance) : 0;
        hi = longint'(nominal) + longint'(key_cfg.tolerance);
        return longint'(len) >= lo && longint'(len) <= hi;
    endfunction

    function automatic key_symbol_t classify_key_event(input logic [ACTION_W-1:0] act,
                                                       input logic [LINE_W-1:0] ln);
        key_symbol_t       res;
        logic [CFG_W-1:0]  short_at;
        res.symbol = SYM_NONE;
        short_at = (key_cfg.dash_time > key_cfg.tolerance)
                   ? key_cfg.dash_time - key_cfg.tolerance : '0;
        case (act)
            ACT_TICK:
            begin
                if (key_st.tone_left != 0)
                begin
                    key_st.tone_left--;
                    key_st.idle_ms = '0;
                end
                else if (key_st.key_down)
                begin
                    if (~&key_st.press_ms)
                        key_st.press_ms++;
                    if (key_st.press_ms >= key_cfg.hold_time)
                    begin
                        res.symbol        = SYM_HOLD;
                        key_st.key_down   = 1'b0;
                        key_st.idle_ms    = '0;
                        key_st.idle_armed = 1'b1;
                    end
                end
                else
                begin
                    if (~&key_st.idle_ms)
                        key_st.idle_ms++;
                    if (key_st.idle_armed && key_st.idle_ms > key_cfg.long_space_time)
                    begin
                        res.symbol        = SYM_LONG;
                        key_st.idle_armed = 1'b0;
                    end
                    else if (key_st.idle_armed && !key_st.short_sent
                             && key_st.idle_ms >= short_at)
                    begin
                        res.symbol        = SYM_SHORT;
                        key_st.short_sent = 1'b1;
                    end
                end
            end
            ACT_PRESS:
            begin
                if (ln == key_cfg.left_paddle_line || ln == key_cfg.right_paddle_line)
                begin
                    if (ln == key_cfg.left_paddle_line)
                    begin
                        res.symbol       = SYM_DOT;
                        key_st.tone_left = tone_length(key_cfg.dot_time);
                    end
                    else
                    begin
                        res.symbol       = SYM_DASH;
                        key_st.tone_left = tone_length(key_cfg.dash_time);
                    end
                    key_st.key_down   = 1'b0;
                    key_st.idle_ms    = '0;
                    key_st.idle_armed = 1'b1;
                    key_st.short_sent = 1'b0;
                end
                else
                begin
                    key_st.tone_left  = '0;
                    key_st.press_ms   = '0;
                    key_st.key_down   = 1'b1;
                    key_st.short_sent = 1'b0;
                end
            end
            ACT_RELEASE:
            begin
                key_st.idle_ms    = '0;
                key_st.idle_armed = 1'b1;
                if (key_st.key_down)
                begin
                    key_st.key_down = 1'b0;
                    if (within_window(key_st.press_ms, key_cfg.dot_time))
                        res.symbol = SYM_DOT;
                    else if (within_window(key_st.press_ms, key_cfg.dash_time))
                        res.symbol = SYM_DASH;
                    else
                        res.symbol = SYM_UNKNOWN;
                end
            end
            default:
            begin
            end
        endcase
        res.tone_on = key_st.key_down || key_st.tone_left != 0;
        return res;
    endfunction

    always @(posedge clk)
    begin : check_symbols
        key_symbol_t want;
        if (rst_n && symbols_if.valid && symbols_if.ready)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("symbol item arrived with none expected: symbol %0d, tone_on %0d",
                       symbols_if.symbol, symbols_if.tone_on);
                error_count++;
            end
            else
            begin
                want = pending_symbols.pop_front();
                if (symbols_if.symbol !== want.symbol)
                begin
                    $error("symbol: expected %0d, got %0d", want.symbol, symbols_if.symbol);
                    error_count++;
                end
                if (symbols_if.tone_on !== want.tone_on)
                begin
                    $error("tone_on: expected %0d, got %0d", want.tone_on, symbols_if.tone_on);
                    error_count++;
                end
            end
        end
    end

    initial
    begin : symbol_sink
        symbols_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_holdoff > 0)
            begin
                sink_holdoff--;
                symbols_if.ready <= 1'b0;
            end
            else
                symbols_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [LINE_W-1:0] ln);
        while ($urandom_range(99) < src_gap_pct)
        begin
            events_if.valid <= 1'b0;
            @(negedge clk);
        end
        events_if.valid  <= 1'b1;
        events_if.action <= act;
        events_if.line   <= ln;
        @(posedge clk);
        while (!events_if.ready)
            @(posedge clk);
        pending_symbols.push_back(classify_key_event(act, ln));
        events_sent++;
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_event(ACT_TICK, LINE_W'($urandom_range(63)));
    endtask

    task automatic drain_symbols();
        int waited;
        events_if.valid <= 1'b0;
        waited = 0;
        while (pending_symbols.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_symbols.size() != 0)
        begin
            $error("%0d symbol items never arrived", pending_symbols.size());
            error_count++;
            pending_symbols.delete();
        end
        repeat (SETTLE_TICKS)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        drain_symbols();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_DOT_TIME:        key_cfg.dot_time          = value;
            REG_DASH_TIME:       key_cfg.dash_time         = value;
            REG_TOLERANCE:       key_cfg.tolerance         = value;
            REG_HOLD_TIME:       key_cfg.hold_time         = value;
            REG_LONG_SPACE_TIME: key_cfg.long_space_time   = value;
            REG_LEFT_PADDLE:     key_cfg.left_paddle_line  = value[LINE_W-1:0];
            REG_RIGHT_PADDLE:    key_cfg.right_paddle_line = value[LINE_W-1:0];
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [CFG_W-1:0] dot, input logic [CFG_W-1:0] dash,
                                 input logic [CFG_W-1:0] tol, input logic [CFG_W-1:0] hold,
                                 input logic [CFG_W-1:0] lng, input logic [CFG_W-1:0] left,
                                 input logic [CFG_W-1:0] right);
        write_reg(REG_DOT_TIME, dot);
        write_reg(REG_DASH_TIME, dash);
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_HOLD_TIME, hold);
        write_reg(REG_LONG_SPACE_TIME, lng);
        write_reg(REG_LEFT_PADDLE, left);
        write_reg(REG_RIGHT_PADDLE, right);
    endtask

    task automatic send_random_traffic(input int n_items);
        int               stop_at;
        int               kind;
        int               n;
        int               nominal;
        int               span;
        logic [LINE_W-1:0] ln;
        stop_at = events_sent + n_items;
        while (events_sent < stop_at)
        begin
            kind = int'($urandom_range(99));
            if (kind < 45)
            begin
                // A key stroke on a random line, timed around the dot, dash or hold length or at random.
                ln = LINE_W'($urandom_range(63));
                send_event(ACT_PRESS, ln);
                case ($urandom_range(3))
                    0:       nominal = int'(key_cfg.dot_time);
                    1:       nominal = int'(key_cfg.dash_time);
                    2:       nominal = int'(key_cfg.hold_time);
                    default: nominal = int'($urandom_range(40));
                endcase
                span = (key_cfg.tolerance < 20) ? int'(key_cfg.tolerance) + 1 : 20;
                n = nominal + int'($urandom_range(2 * span)) - span;
                send_ticks(n < 0 ? 0 : (n > 80 ? 80 : n));
                if ($urandom_range(9) == 0)
                    send_event(ACT_RELEASE, LINE_W'($urandom_range(63)));
                else
                    send_event(ACT_RELEASE, ln);
            end
            else if (kind < 60)
            begin
                ln = $urandom_range(1) ? key_cfg.left_paddle_line : key_cfg.right_paddle_line;
                send_event(ACT_PRESS, ln);
                n = int'(key_cfg.dash_time) + 3;
                send_ticks(int'($urandom_range(n > 80 ? 80 : n)));
            end
            else if (kind < 80)
            begin
                n = int'(key_cfg.long_space_time) + 3;
                send_ticks(int'($urandom_range(n > 80 ? 80 : n)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_event(ACTION_W'($urandom_range(3)), LINE_W'($urandom_range(63)));
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_event(ACT_TICK, 6'd0);
        send_event(ACT_PRESS, RIGHT_PADDLE_RST);
        send_event(ACT_PRESS, LEFT_PADDLE_RST);
        send_event(ACT_PRESS, 6'd2);
        send_event(ACT_RELEASE, 6'd2);
    endtask

    task automatic test_directed_symbols();
        apply_setting(16'd1, 16'd3, 16'd0, 16'd5, 16'd4, 16'd5, 16'd40);
        send_event(ACT_PRESS, 6'd63);
        send_ticks(1);
        send_event(ACT_RELEASE, 6'd63);
        send_event(ACT_PRESS, 6'd0);
        send_ticks(3);
        send_event(ACT_RELEASE, 6'd0);
        send_event(ACT_PRESS, 6'd62);
        send_ticks(2);
        send_event(ACT_RELEASE, 6'd62);
        send_event(ACT_RELEASE, 6'd9);
        send_event(ACT_PRESS, 6'd33);
        send_ticks(5);
        send_ticks(5);
        send_event(ACT_PRESS, 6'd5);
        send_ticks(1);
        send_event(ACT_PRESS, 6'd40);
        send_event(ACT_PRESS, 6'd21);
        send_ticks(1);
        send_event(ACT_RELEASE, 6'd21);
        send_event(2'd3, 6'd42);
    endtask

    task automatic test_config_extremes();
        apply_setting('0, '0, '0, '0, '0, '0, '0);
        send_ticks(2);
        send_event(ACT_PRESS, 6'd0);
        send_event(ACT_PRESS, 6'd63);
        send_ticks(1);
        send_event(ACT_RELEASE, 6'd63);

        // Both paddles on one line: the dot paddle takes precedence.
        apply_setting('1, '1, '1, '1, '1, 16'd63, 16'd63);
        send_event(ACT_PRESS, 6'd63);
        send_ticks(3);
        send_event(ACT_PRESS, 6'd62);
        send_event(ACT_RELEASE, 6'd62);

        // Tolerance larger than the dash length, so the lower bounds taken from the dash length floor at zero.
        apply_setting('1, 16'd2, 16'd5, 16'd100, 16'd100, 16'd10, 16'd11);
        send_event(ACT_PRESS, 6'd30);
        send_event(ACT_RELEASE, 6'd30);
        send_ticks(2);

        // Overlapping windows, where the dot is tested first.
        apply_setting(16'd4, 16'd6, 16'd3, 16'd50, 16'd50, 16'd10, 16'd11);
        send_event(ACT_PRESS, 6'd30);
        send_ticks(5);
        send_event(ACT_RELEASE, 6'd30);
    endtask

    task automatic test_long_limits();
        apply_setting(16'd1, '1, '0, '1, '1, 16'd0, 16'd1);
        send_event(ACT_PRESS, 6'd20);
        send_event(ACT_RELEASE, 6'd20);
        send_ticks(200);
        send_event(ACT_PRESS, 6'd20);
        send_ticks(200);
    endtask

    task automatic test_backpressure();
        apply_setting(16'd2, 16'd5, 16'd1, 16'd9, 16'd6, 16'd3, 16'd4);
        src_gap_pct  = 0;
        sink_holdoff = 150;
        send_random_traffic(60);
        src_gap_pct  = 7;
        send_random_traffic(30);
        drain_symbols();
        send_random_traffic(30);
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        send_random_traffic(300);
        src_gap_pct    = 7;
        sink_stall_pct = 7;
    endtask

    task automatic test_random_settings();
        logic [CFG_W-1:0] dot;
        logic [CFG_W-1:0] dash;
        logic [CFG_W-1:0] tol;
        logic [CFG_W-1:0] hold;
        logic [CFG_W-1:0] lng;
        logic [CFG_W-1:0] left;
        logic [CFG_W-1:0] right;
        for (int phase = 0; phase < 8; phase++)
        begin
            dot   = CFG_W'($urandom_range(1, 5));
            dash  = dot + CFG_W'($urandom_range(1, 12));
            tol   = CFG_W'($urandom_range(3));
            hold  = CFG_W'($urandom_range(5, 40));
            lng   = CFG_W'($urandom_range(3, 30));
            left  = CFG_W'($urandom_range(63));
            right = CFG_W'($urandom_range(63));
            case (phase % 6)
                1: tol = CFG_W'($urandom_range(20));
                2: right = left;
                3:
                begin
                    dot  = '0;
                    tol  = '0;
                    hold = CFG_W'($urandom_range(3));
                    lng  = '0;
                end
                4:
                begin
                    dash = CFG_W'($urandom_range(3));
                    tol  = CFG_W'($urandom_range(4, 10));
                end
                5:
                begin
                    dot   = CFG_W'($urandom_range(16'hFFFF));
                    dash  = CFG_W'($urandom_range(16'hFFFF));
                    tol   = CFG_W'($urandom_range(16'hFFFF));
                    hold  = CFG_W'($urandom_range(16'hFFFF));
                    lng   = CFG_W'($urandom_range(16'hFFFF));
                    left  = CFG_W'($urandom_range(16'hFFFF));
                    right = CFG_W'($urandom_range(16'hFFFF));
                end
                default:
                begin
                end
            endcase
            apply_setting(dot, dash, tol, hold, lng, left, right);
            send_random_traffic(150);
        end
    endtask

    initial
    begin : stimulus
        events_if.valid  = 1'b0;
        events_if.action = ACT_TICK;
        events_if.line   = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_DOT_TIME;
        cfg_if.data      = '0;
        rst_n            = 1'b0;

        key_cfg.dot_time          = DOT_TIME_RST;
        key_cfg.dash_time         = DASH_TIME_RST;
        key_cfg.tolerance         = TOLERANCE_RST;
        key_cfg.hold_time         = HOLD_TIME_RST;
        key_cfg.long_space_time   = LONG_SPACE_TIME_RST;
        key_cfg.left_paddle_line  = LEFT_PADDLE_RST;
        key_cfg.right_paddle_line = RIGHT_PADDLE_RST;
        key_st.key_down   = 1'b0;
        key_st.press_ms   = '0;
        key_st.idle_ms    = '0;
        key_st.idle_armed = 1'b1;
        key_st.short_sent = 1'b0;
        key_st.tone_left  = '0;

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_directed_symbols();
        test_config_extremes();
        test_long_limits();
        test_backpressure();
        test_random_settings();
        drain_symbols();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
